// ===== src/depth_mask_pixel_conditioner_top_assert.svh =====
// Assertion macros for the depth and mask pixel conditioner.
`ifndef DEPTH_MASK_PIXEL_CONDITIONER_TOP_ASSERT_SVH
`define DEPTH_MASK_PIXEL_CONDITIONER_TOP_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define DMPC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("dmpc check failed");

// Clocked check that also holds during reset.
`define DMPC_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("dmpc check failed");

`endif

// ===== src/dmpc_pkg.sv =====
// Types, constants and register codes of the depth and mask pixel conditioner.
package dmpc_pkg;

	localparam int COUNT_WIDTH   = 22;
	localparam int COUNT_FIELD_W = 22;
	localparam int CFG_IDX_W     = 3;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	localparam logic [7:0]  RST_MASK_THRESHOLD = 8'd0;
	localparam logic [31:0] RST_COUNT_SCALE    = 32'd16777;
	localparam logic [31:0] RST_DEPTH_MIN      = 32'd6554;
	localparam logic [31:0] RST_DEPTH_MAX      = 32'd655360;
	localparam logic        RST_FLOAT_INPUT    = 1'b0;

	// exponent at which the 24-bit mantissa lands exactly on Q16.16
	localparam logic [7:0]  F_EXP_Q16   = 8'd134;
	localparam logic [7:0]  F_EXP_INF   = 8'hFF;
	localparam logic [7:0]  F_LSH_SAT   = 8'd9;
	localparam logic [7:0]  F_RSH_ZERO  = 8'd24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MASK_THRESHOLD = 3'd0,
		REG_COUNT_SCALE    = 3'd1,
		REG_DEPTH_MIN      = 3'd2,
		REG_DEPTH_MAX      = 3'd3,
		REG_FLOAT_INPUT    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] raw_depth;
		logic [7:0]  mask_byte;
		logic        frame_end;
	} in_t;

	typedef struct packed {
		logic [31:0]              depth_meters;
		logic                     robot_flag;
		logic                     depth_valid;
		logic                     last_pixel;
		logic [COUNT_FIELD_W-1:0] masked_count;
		logic [COUNT_FIELD_W-1:0] filtered_count;
		logic [COUNT_FIELD_W-1:0] active_count;
	} out_t;

	typedef struct packed {
		logic [7:0]  mask_threshold;
		logic [31:0] count_scale;
		logic [31:0] depth_min;
		logic [31:0] depth_max;
		logic        float_input;
	} cfg_t;

	typedef struct packed {
		logic [31:0] q;
		logic        ok;
	} conv_t;

	typedef struct packed {
		logic [COUNT_FIELD_W-1:0] masked;
		logic [COUNT_FIELD_W-1:0] filtered;
		logic [COUNT_FIELD_W-1:0] active;
	} cnt_t;

endpackage

// ===== src/dmpc_cfg.sv =====
// Configuration register file.
module dmpc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [dmpc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [31:0]                     wr_data,
	output dmpc_pkg::cfg_t                  cfg
);
	import dmpc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mask_threshold <= RST_MASK_THRESHOLD;
			cfg_q.count_scale    <= RST_COUNT_SCALE;
			cfg_q.depth_min      <= RST_DEPTH_MIN;
			cfg_q.depth_max      <= RST_DEPTH_MAX;
			cfg_q.float_input    <= RST_FLOAT_INPUT;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_MASK_THRESHOLD: cfg_q.mask_threshold <= wr_data[7:0];
				REG_COUNT_SCALE:    cfg_q.count_scale    <= wr_data;
				REG_DEPTH_MIN:      cfg_q.depth_min      <= wr_data;
				REG_DEPTH_MAX:      cfg_q.depth_max      <= wr_data;
				REG_FLOAT_INPUT:    cfg_q.float_input    <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/dmpc_conv.sv =====
// Depth conversion to Q16.16 meters with finiteness and range checks.
module dmpc_conv (
	input  dmpc_pkg::cfg_t  cfg,
	input  logic [31:0]     raw_depth,
	output dmpc_pkg::conv_t res
);
	import dmpc_pkg::*;

	logic [47:0] prod;
	logic [31:0] cnt_q;
	logic [7:0]  f_exp;
	logic [31:0] f_mant;
	logic [7:0]  sh;
	logic [31:0] f_q;
	logic        f_ok;
	logic [31:0] q_pre;
	logic        ok_pre;
	logic        in_range;

	always_comb begin
		prod  = 48'(raw_depth[15:0]) * 48'(cfg.count_scale);
		cnt_q = (prod[47:40] != 8'd0) ? 32'hFFFF_FFFF : prod[39:8];

		f_exp  = raw_depth[30:23];
		f_mant = {8'd0, 1'b1, raw_depth[22:0]};
		f_ok   = (f_exp != F_EXP_INF) && !(raw_depth[31] && (raw_depth[30:0] != 31'd0));
		sh     = 8'd0;
		if (f_exp == 8'd0) begin
			f_q = 32'd0;
		end else if (f_exp >= F_EXP_Q16) begin
			sh  = f_exp - F_EXP_Q16;
			f_q = (sh >= F_LSH_SAT) ? 32'hFFFF_FFFF : (f_mant << sh[3:0]);
		end else begin
			sh  = F_EXP_Q16 - f_exp;
			f_q = (sh >= F_RSH_ZERO) ? 32'd0 : (f_mant >> sh[4:0]);
		end

		q_pre    = cfg.float_input ? f_q : cnt_q;
		ok_pre   = cfg.float_input ? f_ok : 1'b1;
		in_range = (q_pre >= cfg.depth_min) && (q_pre <= cfg.depth_max);
		res.ok   = ok_pre && in_range;
		res.q    = res.ok ? q_pre : 32'd0;
	end

endmodule

// ===== src/dmpc_count.sv =====
// Per-frame saturating pixel counters.
module dmpc_count (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          robot,
	input  logic          ok,
	input  logic          last,
	output dmpc_pkg::cnt_t cnt
);
	import dmpc_pkg::*;

	logic [COUNT_WIDTH-1:0] masked_q, filtered_q, active_q;
	logic [COUNT_WIDTH-1:0] masked_nx, filtered_nx, active_nx;

	always_comb begin
		masked_nx   = (robot && masked_q != COUNT_MAX) ? masked_q + 1'b1 : masked_q;
		active_nx   = (ok && active_q != COUNT_MAX) ? active_q + 1'b1 : active_q;
		filtered_nx = (!ok && filtered_q != COUNT_MAX) ? filtered_q + 1'b1 : filtered_q;
		if (last) begin
			cnt.masked   = COUNT_FIELD_W'(masked_nx);
			cnt.filtered = COUNT_FIELD_W'(filtered_nx);
			cnt.active   = COUNT_FIELD_W'(active_nx);
		end else begin
			cnt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			masked_q   <= '0;
			filtered_q <= '0;
			active_q   <= '0;
		end else if (step) begin
			masked_q   <= last ? '0 : masked_nx;
			filtered_q <= last ? '0 : filtered_nx;
			active_q   <= last ? '0 : active_nx;
		end
	end

endmodule

// ===== src/depth_mask_pixel_conditioner_top.sv =====
// Top level of the depth and mask pixel conditioner.
//
//   channel | dir | handshake         | payload
//   in      | in  | in_valid/in_stall | in_data (raw_depth, mask_byte, frame_end)
//   out     | out | out_valid/out_stall | out_data (depth, flags, frame counts)
//   cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One pixel per clock sustained while out_stall is low; out_valid follows the result register.
// Input register, then conversion, range check and counters feed the result register.
// Reset clears valid bits, counters and loads register defaults.
// in_stall rises only when both registers hold a beat and out_stall is high.
module depth_mask_pixel_conditioner_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  dmpc_pkg::in_t                  in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output dmpc_pkg::out_t                 out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dmpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);
	import dmpc_pkg::*;

	cfg_t  cfg;
	conv_t conv;
	cnt_t  cnt;

	in_t   in_s1;
	logic  v_s1;
	out_t  out_s2;
	logic  v_s2;

	logic  adv2;
	logic  load2;
	logic  robot;

	assign cfg_ready = 1'b1;
	assign adv2      = !v_s2 || !out_stall;
	assign load2     = v_s1 && adv2;
	assign in_stall  = v_s1 && !adv2;
	assign robot     = in_s1.mask_byte > cfg.mask_threshold;

	dmpc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	dmpc_conv u_conv (
		.cfg       (cfg),
		.raw_depth (in_s1.raw_depth),
		.res       (conv)
	);

	dmpc_count u_count (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (load2),
		.robot  (robot),
		.ok     (conv.ok),
		.last   (in_s1.frame_end),
		.cnt    (cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (!in_stall) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) in_s1 <= in_data;
		if (load2) begin
			out_s2.depth_meters   <= conv.q;
			out_s2.robot_flag     <= robot;
			out_s2.depth_valid    <= conv.ok;
			out_s2.last_pixel     <= in_s1.frame_end;
			out_s2.masked_count   <= cnt.masked;
			out_s2.filtered_count <= cnt.filtered;
			out_s2.active_count   <= cnt.active;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = out_s2;

endmodule

// ===== src/dmpc_checker.sv =====
// Port-level checks of the depth and mask pixel conditioner, bound to the top level.
`include "depth_mask_pixel_conditioner_top_assert.svh"

module dmpc_port_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input dmpc_pkg::out_t                 out_data
);
	import dmpc_pkg::*;

	logic counts_clear;
	logic frame_counted;

	assign counts_clear  = (out_data.masked_count == '0) && (out_data.filtered_count == '0)
		&& (out_data.active_count == '0);
	assign frame_counted = (out_data.filtered_count != '0) || (out_data.active_count != '0);

	`DMPC_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(out_data))

	`DMPC_ASSERT(a_stall_backs_up, clk, arst_n, in_stall |-> out_valid && out_stall)

	`DMPC_ASSERT(a_counts_zero_mid, clk, arst_n, out_valid && !out_data.last_pixel |-> counts_clear)

	`DMPC_ASSERT(a_rejected_zero, clk, arst_n, out_valid && !out_data.depth_valid |-> out_data.depth_meters == 32'd0)

	`DMPC_ASSERT(a_frame_nonempty, clk, arst_n, out_valid && out_data.last_pixel |-> frame_counted)

endmodule

bind depth_mask_pixel_conditioner_top dmpc_port_checker u_dmpc_port_checker (.*);
